// ===== sv/scc_pkg.sv =====
`default_nettype none
package scc_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned MaxArcs  = 512;

  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned CountW   = $clog2(MaxNodes + 1);
  localparam int unsigned ArcAddrW = $clog2(MaxArcs);
  localparam int unsigned ArcCntW  = $clog2(MaxArcs + 1);
  localparam int unsigned CfgW     = 7;
  localparam int unsigned AddrW    = 3;

  localparam logic [CfgW-1:0] NodeCountReset = CfgW'(MaxNodes);
  localparam logic RegNodeCount = 1'b0;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActSolve = 1'b1;

  typedef logic [MaxNodes-1:0] node_vec_t;
  typedef logic [NodeW-1:0]    node_t;

  typedef struct packed {
    logic busy;
    logic done;
  } solve_stat_t;

  // Index of the lowest set bit; zero when the vector is empty.
  function automatic node_t lowest(input node_vec_t v);
    node_t r;
    r = '0;
    for (int i = MaxNodes - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = node_t'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/scc_ram.sv =====
`default_nettype none
module scc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/scc_walk.sv =====
`default_nettype none
module scc_walk (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         solve_i,
  input  wire logic [scc_pkg::CountW-1:0]   n_i,
  input  wire logic [scc_pkg::ArcCntW-1:0]  arc_total_i,
  input  wire logic                         ovf_i,
  output logic      [scc_pkg::ArcAddrW-1:0] arc_raddr_o,
  input  wire logic [2*scc_pkg::NodeW-1:0]  arc_rdata_i,
  output scc_pkg::solve_stat_t              stat_o,
  output logic                              result_valid_o,
  output logic      [scc_pkg::NodeW-1:0]    node_number_o,
  output logic      [scc_pkg::NodeW-1:0]    component_leader_o,
  output logic                              component_end_o,
  output logic                              last_o,
  output logic                              arcs_dropped_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPick = 3'd1;
  localparam logic [2:0] StPop  = 3'd2;
  localparam logic [2:0] StScan = 3'd3;
  localparam logic [2:0] StComp = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;

  logic [2:0] state_q, state_d;
  scc_pkg::node_vec_t fwd_q, fwd_d, bwd_q, bwd_d, pend_q, pend_d;
  scc_pkg::node_vec_t asg_q, asg_d, comp_q, comp_d, rmask;
  scc_pkg::node_t leader_q, leader_d, node_q, node_d;
  logic [scc_pkg::ArcCntW-1:0] addr_q, addr_d;
  logic vld_q, vld_d;
  logic res_vld_d, res_end_d, res_last_d;
  scc_pkg::node_t res_node_d;
  logic done;

  always_comb begin
    for (int i = 0; i < scc_pkg::MaxNodes; i++) begin
      rmask[i] = scc_pkg::CountW'(i) < n_i;
    end
  end

  assign arc_raddr_o = addr_q[scc_pkg::ArcAddrW-1:0];

  always_comb begin
    scc_pkg::node_vec_t free;
    scc_pkg::node_vec_t one;
    scc_pkg::node_vec_t rest;
    scc_pkg::node_t t;
    scc_pkg::node_t h;
    scc_pkg::node_t v;
    state_d    = state_q;
    fwd_d      = fwd_q;
    bwd_d      = bwd_q;
    pend_d     = pend_q;
    asg_d      = asg_q;
    comp_d     = comp_q;
    leader_d   = leader_q;
    node_d     = node_q;
    addr_d     = addr_q;
    vld_d      = 1'b0;
    res_vld_d  = 1'b0;
    res_end_d  = 1'b0;
    res_last_d = 1'b0;
    res_node_d = '0;
    done       = 1'b0;
    free = ~asg_q & rmask;
    t    = arc_rdata_i[2*scc_pkg::NodeW-1:scc_pkg::NodeW];
    h    = arc_rdata_i[scc_pkg::NodeW-1:0];
    v    = scc_pkg::lowest(comp_q);
    rest = comp_q & ~(scc_pkg::node_vec_t'(1) << v);
    one  = '0;
    case (state_q)
      StIdle: begin
        if (solve_i) begin
          asg_d   = '0;
          state_d = StPick;
        end
      end
      StPick: begin
        if (free == '0) begin
          done    = 1'b1;
          state_d = StIdle;
        end else begin
          leader_d = scc_pkg::lowest(free);
          one      = scc_pkg::node_vec_t'(1) << leader_d;
          fwd_d    = one;
          bwd_d    = one;
          pend_d   = one;
          state_d  = StPop;
        end
      end
      StPop: begin
        if (pend_q == '0) begin
          state_d = StComp;
        end else begin
          node_d         = scc_pkg::lowest(pend_q);
          pend_d[node_d] = 1'b0;
          // Nodes already in an earlier component are not expanded.
          if (!asg_q[node_d] && arc_total_i != '0) begin
            addr_d  = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (addr_q < arc_total_i) begin
          addr_d = addr_q + 1'b1;
          vld_d  = 1'b1;
        end
        if (vld_q && scc_pkg::CountW'(t) < n_i && scc_pkg::CountW'(h) < n_i) begin
          if (t == node_q && fwd_q[node_q] && !fwd_q[h]) begin
            fwd_d[h]  = 1'b1;
            pend_d[h] = 1'b1;
          end
          if (h == node_q && bwd_q[node_q] && !bwd_q[t]) begin
            bwd_d[t]  = 1'b1;
            pend_d[t] = 1'b1;
          end
        end
        if (addr_q >= arc_total_i && !vld_q) begin
          state_d = StPop;
        end
      end
      StComp: begin
        comp_d  = fwd_q & bwd_q & ~asg_q & rmask;
        state_d = StEmit;
      end
      StEmit: begin
        res_vld_d  = 1'b1;
        res_node_d = v;
        res_end_d  = rest == '0;
        res_last_d = (rest == '0) && (&(asg_q | comp_q | ~rmask));
        asg_d[v]   = 1'b1;
        comp_d     = rest;
        if (rest == '0) begin
          state_d = StPick;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      vld_q          <= 1'b0;
      asg_q          <= '0;
      fwd_q          <= '0;
      bwd_q          <= '0;
      pend_q         <= '0;
      comp_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      vld_q          <= vld_d;
      asg_q          <= asg_d;
      fwd_q          <= fwd_d;
      bwd_q          <= bwd_d;
      pend_q         <= pend_d;
      comp_q         <= comp_d;
      result_valid_o <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    leader_q <= leader_d;
    node_q   <= node_d;
    addr_q   <= addr_d;
    if (res_vld_d) begin
      node_number_o      <= res_node_d;
      component_leader_o <= leader_q;
      component_end_o    <= res_end_d;
      last_o             <= res_last_d;
      arcs_dropped_o     <= ovf_i;
    end
  end

  assign stat_o.busy = state_q != StIdle;
  assign stat_o.done = done;

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> stat_o.busy) else $error("result outside a solve");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o) else $error("result after last");
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> comp_q != '0) else $error("empty component");
  a_pend_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q & ~(fwd_q | bwd_q)) == '0) else $error("pending node unmarked");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |=> !stat_o.busy) else $error("done without idle");

endmodule
`default_nettype wire

// ===== sv/strongly_connected_components.sv =====
// Arc load: busy stays low, so loads may follow each other every cycle.
// Solve, per component: pick the leader, then take the nodes from the pending set one by one,
// making a pass over the stored arcs for each taken node not yet assigned, and once the set
// is empty, close the component and emit its nodes one by one.
// Results come one a cycle within a component, the receiver cannot stall them, and a final
// pick that finds no free node ends the solve. Reset (asynchronous, active low) empties the arc store.
`default_nettype none
module strongly_connected_components (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       action_i,
  input  wire logic [scc_pkg::NodeW-1:0]  arc_source_i,
  input  wire logic [scc_pkg::NodeW-1:0]  arc_target_i,
  output logic                            result_valid_o,
  output logic      [scc_pkg::NodeW-1:0]  node_number_o,
  output logic      [scc_pkg::NodeW-1:0]  component_leader_o,
  output logic                            component_end_o,
  output logic                            last_o,
  output logic                            arcs_dropped_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [scc_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  logic [scc_pkg::CfgW-1:0] node_count_q;
  logic [scc_pkg::CountW-1:0] n_eff;
  logic [scc_pkg::ArcCntW-1:0] arc_total_q;
  logic ovf_q, load, drop;
  logic [scc_pkg::ArcAddrW-1:0] raddr;
  logic [2*scc_pkg::NodeW-1:0] rdata;
  scc_pkg::solve_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr[scc_pkg::AddrW-1] == scc_pkg::RegNodeCount)
                ? {{(32 - scc_pkg::CfgW){1'b0}}, node_count_q} : '0;

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = scc_pkg::CountW'(1);
    end else if (node_count_q > scc_pkg::CfgW'(scc_pkg::MaxNodes)) begin
      n_eff = scc_pkg::CountW'(scc_pkg::MaxNodes);
    end else begin
      n_eff = node_count_q[scc_pkg::CountW-1:0];
    end
  end

  assign busy = stat.busy;
  assign load = start && !busy && (action_i == scc_pkg::ActLoad);
  assign drop = arc_total_q >= scc_pkg::ArcCntW'(scc_pkg::MaxArcs)
             || scc_pkg::CountW'(arc_source_i) >= n_eff
             || scc_pkg::CountW'(arc_target_i) >= n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= scc_pkg::NodeCountReset;
      arc_total_q  <= '0;
      ovf_q        <= 1'b0;
    end else begin
      if (psel && penable && pwrite
          && paddr[scc_pkg::AddrW-1] == scc_pkg::RegNodeCount) begin
        node_count_q <= pwdata[scc_pkg::CfgW-1:0];
      end
      if (stat.done) begin
        arc_total_q <= '0;
        ovf_q       <= 1'b0;
      end else if (load) begin
        if (drop) begin
          ovf_q <= 1'b1;
        end else begin
          arc_total_q <= arc_total_q + 1'b1;
        end
      end
    end
  end

  scc_ram #(
    .Width (2 * scc_pkg::NodeW),
    .Depth (scc_pkg::MaxArcs)
  ) u_arcs (
    .clk_i   (clk_i),
    .we_i    (load && !drop),
    .waddr_i (arc_total_q[scc_pkg::ArcAddrW-1:0]),
    .wdata_i ({arc_source_i, arc_target_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  scc_walk u_walk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .solve_i            (start && (action_i == scc_pkg::ActSolve)),
    .n_i                (n_eff),
    .arc_total_i        (arc_total_q),
    .ovf_i              (ovf_q),
    .arc_raddr_o        (raddr),
    .arc_rdata_i        (rdata),
    .stat_o             (stat),
    .result_valid_o     (result_valid_o),
    .node_number_o      (node_number_o),
    .component_leader_o (component_leader_o),
    .component_end_o    (component_end_o),
    .last_o             (last_o),
    .arcs_dropped_o     (arcs_dropped_o)
  );

endmodule
`default_nettype wire

// ===== test/strongly_connected_components_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module strongly_connected_components_tb;

  typedef struct {
    logic           act;
    scc_pkg::node_t src;
    scc_pkg::node_t dst;
  } arc_cmd_t;

  typedef struct {
    scc_pkg::node_t node;
    scc_pkg::node_t leader;
    logic           comp_end;
    logic           fin;
    logic           dropped;
  } member_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic action_i = 1'b0;
  scc_pkg::node_t arc_source_i = '0;
  scc_pkg::node_t arc_target_i = '0;
  logic result_valid_o;
  scc_pkg::node_t node_number_o, component_leader_o;
  logic component_end_o, last_o, arcs_dropped_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [scc_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic taken = 1'b0;

  strongly_connected_components dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .arc_source_i, .arc_target_i,
    .result_valid_o, .node_number_o, .component_leader_o, .component_end_o,
    .last_o, .arcs_dropped_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  scc_pkg::node_t tails[scc_pkg::MaxArcs];
  scc_pkg::node_t heads[scc_pkg::MaxArcs];
  int unsigned arcs_held = 0;
  logic dropped_seen = 1'b0;
  logic [scc_pkg::CfgW-1:0] node_cfg = scc_pkg::NodeCountReset;

  arc_cmd_t pending[$];
  member_t members_due[$];
  int errors = 0;
  int idle_pct = 0;

  function automatic int unsigned nodes_in_use();
    if (node_cfg == 0) return 1;
    if (node_cfg > scc_pkg::MaxNodes) return scc_pkg::MaxNodes;
    return node_cfg;
  endfunction

  // Forward/backward reachability split of the stored graph into components.
  task automatic predict_components();
    int unsigned n;
    logic done_v[scc_pkg::MaxNodes];
    logic fw[scc_pkg::MaxNodes];
    logic bw[scc_pkg::MaxNodes];
    int stk[$];
    int nd, t, h, tail_node;
    member_t m;
    n = nodes_in_use();
    foreach (done_v[i]) done_v[i] = 1'b0;
    for (int ld = 0; ld < n; ld++) begin
      if (done_v[ld]) continue;
      foreach (fw[i]) begin
        fw[i] = 1'b0;
        bw[i] = 1'b0;
      end
      fw[ld] = 1'b1;
      bw[ld] = 1'b1;
      stk = {ld};
      while (stk.size() > 0) begin
        nd = stk.pop_back();
        if (nd >= n || done_v[nd]) continue;
        for (int a = 0; a < arcs_held; a++) begin
          t = tails[a];
          h = heads[a];
          if (t >= n || h >= n) continue;
          if (t == nd && fw[nd] && !fw[h]) begin
            fw[h] = 1'b1;
            stk.push_back(h);
          end
          if (h == nd && bw[nd] && !bw[t]) begin
            bw[t] = 1'b1;
            stk.push_back(t);
          end
        end
      end
      tail_node = ld;
      for (int v = ld; v < n; v++)
        if (!done_v[v] && fw[v] && bw[v]) tail_node = v;
      for (int v = ld; v < n; v++) begin
        if (done_v[v] || !fw[v] || !bw[v]) continue;
        done_v[v] = 1'b1;
        m.node = scc_pkg::node_t'(v);
        m.leader = scc_pkg::node_t'(ld);
        m.comp_end = (v == tail_node);
        m.fin = 1'b0;
        m.dropped = dropped_seen;
        members_due.push_back(m);
      end
    end
    members_due[members_due.size()-1].fin = 1'b1;
    arcs_held = 0;
    dropped_seen = 1'b0;
  endtask

  task automatic predict_cmd(input arc_cmd_t c);
    if (c.act == scc_pkg::ActLoad) begin
      if (arcs_held >= scc_pkg::MaxArcs || c.src >= nodes_in_use()
          || c.dst >= nodes_in_use()) begin
        dropped_seen = 1'b1;
      end else begin
        tails[arcs_held] = c.src;
        heads[arcs_held] = c.dst;
        arcs_held++;
      end
    end else begin
      predict_components();
    end
  endtask

  // The acceptance edge is recorded here and acted on by the driver on the falling clock edge.
  always @(posedge clk_i) begin
    taken <= rst_ni && start && !busy;
  end

  // Driver: one transaction from the queue per accepted start.
  always @(negedge clk_i) begin
    if (taken) begin
      predict_cmd(pending.pop_front());
    end
    if (start && !taken) begin
      // The block is busy: hold the transaction until it is taken.
    end else if (rst_ni && pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      action_i <= pending[0].act;
      arc_source_i <= pending[0].src;
      arc_target_i <= pending[0].dst;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (result_valid_o) begin
      if (members_due.size() == 0) begin
        $error("unexpected result node %0d", node_number_o);
        errors++;
      end else begin
        member_t e;
        e = members_due.pop_front();
        if (node_number_o !== e.node) begin
          $error("node_number exp %0d got %0d", e.node, node_number_o);
          errors++;
        end
        if (component_leader_o !== e.leader) begin
          $error("component_leader exp %0d got %0d", e.leader, component_leader_o);
          errors++;
        end
        if (component_end_o !== e.comp_end) begin
          $error("component_end exp %0d got %0d", e.comp_end, component_end_o);
          errors++;
        end
        if (last_o !== e.fin) begin
          $error("last exp %0d got %0d", e.fin, last_o);
          errors++;
        end
        if (arcs_dropped_o !== e.dropped) begin
          $error("arcs_dropped exp %0d got %0d", e.dropped, arcs_dropped_o);
          errors++;
        end
      end
    end
  end

  task automatic queue_cmd(input logic act, input int s, input int d);
    arc_cmd_t c;
    c.act = act;
    c.src = scc_pkg::node_t'(s);
    c.dst = scc_pkg::node_t'(d);
    pending.push_back(c);
  endtask

  task automatic drain();
    while (pending.size() > 0 || start || members_due.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_node_count(input int v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= scc_pkg::AddrW'(4 * scc_pkg::RegNodeCount);
    pwdata <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    node_cfg = scc_pkg::CfgW'(v);
  endtask

  // A random graph: mostly in-range arcs, a few that may be out of range.
  task automatic queue_graph(input int n, input int arcs);
    for (int i = 0; i < arcs; i++) begin
      if ($urandom_range(15) == 0) begin
        queue_cmd(scc_pkg::ActLoad, $urandom_range(63), $urandom_range(63));
      end else begin
        queue_cmd(scc_pkg::ActLoad, $urandom_range(n - 1), $urandom_range(n - 1));
      end
    end
    queue_cmd(scc_pkg::ActSolve, $urandom_range(63), $urandom_range(63));
  endtask

  initial begin
    int cfgs[6] = '{64, 1, 0, 127, 8, 20};
    int modes[4] = '{0, 85, 0, 20};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: empty graph, a cycle, extremes, out-of-range arcs.
    queue_cmd(scc_pkg::ActSolve, 0, 0);
    queue_cmd(scc_pkg::ActLoad, 0, 63);
    queue_cmd(scc_pkg::ActLoad, 63, 0);
    queue_cmd(scc_pkg::ActLoad, 5, 5);
    queue_cmd(scc_pkg::ActLoad, 42, 21);
    queue_cmd(scc_pkg::ActLoad, 21, 42);
    queue_cmd(scc_pkg::ActLoad, 1, 2);
    queue_cmd(scc_pkg::ActSolve, 63, 63);
    drain();
    write_node_count(4);
    queue_cmd(scc_pkg::ActLoad, 0, 1);
    queue_cmd(scc_pkg::ActLoad, 1, 0);
    queue_cmd(scc_pkg::ActLoad, 2, 9);
    queue_cmd(scc_pkg::ActLoad, 3, 2);
    queue_cmd(scc_pkg::ActLoad, 2, 3);
    drain();
    // Lowering the count after loading makes stored arcs that touch nodes beyond it invisible.
    write_node_count(2);
    queue_cmd(scc_pkg::ActSolve, 0, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct = modes[p];
      for (int c = 0; c < 6; c++) begin
        write_node_count(cfgs[(c + p) % 6]);
        queue_graph(nodes_in_use(), $urandom_range(6, 16));
        drain();
      end
    end
    idle_pct = 0;

    if (errors == 0) $display("strongly_connected_components_tb: done, clean");
    else $display("strongly_connected_components_tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("strongly_connected_components_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
